// File: rtl/chroma_pair_to_luma_visualizer_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef CHROMA_PAIR_TO_LUMA_VISUALIZER_MACROS_SVH
`define CHROMA_PAIR_TO_LUMA_VISUALIZER_MACROS_SVH

// Same-cycle implication, sampled on clock.
`define CPL_ASSERT_IMP(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock.
`define CPL_ASSERT_NXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cpl_pkg.sv
`timescale 1ns / 1ps
package cpl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DEPTH_W    = 5;
   localparam int CSR_W      = 5;
   localparam int SQ_W       = 2 * SAMPLE_W;
   localparam int SQRT_STEPS = SAMPLE_W;

   localparam logic [DEPTH_W-1:0] MIN_DEPTH   = DEPTH_W'(8);
   localparam logic [DEPTH_W-1:0] MAX_DEPTH   = DEPTH_W'(SAMPLE_W);
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(8);

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_DEPTH = 1'b1;

   typedef enum logic [2:0] {
      MODE_MAGNITUDE    = 3'd0,
      MODE_AVERAGE      = 3'd1,
      MODE_DIFFERENCE   = 3'd2,
      MODE_MAX          = 3'd3,
      MODE_MIN          = 3'd4,
      MODE_EXTRACTCLIP  = 3'd5,
      MODE_EXTRACTSCALE = 3'd6,
      MODE_SUMCLIP      = 3'd7
   } mode_type;

   // Control that rides along with each item down the pipe.
   typedef struct packed {
      logic                valid;
      logic                magnitude;
      logic [SAMPLE_W-1:0] full_scale;
      logic [SAMPLE_W-1:0] alt_result;
   } pipe_ctl_type;

   // Full scale 2^d - 1 with d clamped to the supported depth range.
   function automatic logic [SAMPLE_W-1:0] full_scale(input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W-1:0]  d;
      logic [SAMPLE_W:0]   pow;
      d = depth;
      if (depth < MIN_DEPTH) d = MIN_DEPTH;
      if (depth > MAX_DEPTH) d = MAX_DEPTH;
      pow = (SAMPLE_W + 1)'(1) << d;
      return SAMPLE_W'(pow - 1'b1);
   endfunction

endpackage

// File: rtl/cpl_if.sv
`timescale 1ns / 1ps
interface cpl_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpl_pkg::SAMPLE_W-1:0]  u_sample;
   logic [cpl_pkg::SAMPLE_W-1:0]  v_sample;

   modport source (output valid, output u_sample, output v_sample, input ready);
   modport sink   (input valid, input u_sample, input v_sample, output ready);
endinterface

interface cpl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cpl_pkg::SAMPLE_W-1:0]  luma_value;

   modport source (output valid, output luma_value, input ready);
   modport sink   (input valid, input luma_value, output ready);
endinterface

// File: rtl/cpl_front.sv
`timescale 1ns / 1ps
// Three stages: mask and fold about mid, square and cheap modes, sum of squares.
module cpl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [cpl_pkg::SAMPLE_W-1:0]      u_sample,
   input  logic [cpl_pkg::SAMPLE_W-1:0]      v_sample,
   input  cpl_pkg::mode_type                 mode,
   input  logic [cpl_pkg::DEPTH_W-1:0]       depth,
   output cpl_pkg::pipe_ctl_type             ctl_out,
   output logic [cpl_pkg::SQ_W-1:0]          q_out
);

   localparam int W = cpl_pkg::SAMPLE_W;

   // |2x - s|
   function automatic logic [W-1:0] dist_mid(input logic [W-1:0] x, input logic [W-1:0] s);
      logic [W:0] x2;
      logic [W:0] s1;
      x2 = {x, 1'b0};
      s1 = {1'b0, s};
      if (x2 >= s1) return W'(x2 - s1);
      else          return W'(s1 - x2);
   endfunction

   // Clip a doubled value to [0, lim].
   function automatic logic [W:0] clip_dbl(input logic signed [W+2:0] t,
                                           input logic signed [W+2:0] lim);
      if (t < 0)        return '0;
      else if (t > lim) return lim[W:0];
      else              return t[W:0];
   endfunction

   // Halve a doubled value, ties to even.
   function automatic logic [W-1:0] half_even(input logic [W:0] t);
      logic [W-1:0] q;
      q = t[W:1];
      if (t[0] && q[0]) q = q + 1'b1;
      return q;
   endfunction

   // stage A
   logic                   a_valid_ff;
   cpl_pkg::mode_type      a_mode_ff;
   logic [W-1:0]           a_u_ff, a_v_ff, a_s_ff, a_da_ff, a_db_ff;
   logic [W-1:0]           s_in, u_in, v_in;

   // stage B
   cpl_pkg::pipe_ctl_type  b_ctl_ff, b_ctl_in;
   logic [2*W-1:0]         b_sqa_ff, b_sqb_ff;

   // stage C
   cpl_pkg::pipe_ctl_type  c_ctl_ff;
   logic [2*W-1:0]         c_q_ff, c_q_in;

   logic signed [W+2:0]    two_s, t5, t6, t7;

   always_comb begin
      s_in = cpl_pkg::full_scale(depth);
      u_in = u_sample & s_in;
      v_in = v_sample & s_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
      if (adv) begin
         a_mode_ff <= mode;
         a_u_ff    <= u_in;
         a_v_ff    <= v_in;
         a_s_ff    <= s_in;
         a_da_ff   <= dist_mid(u_in, s_in);
         a_db_ff   <= dist_mid(v_in, s_in);
      end
   end

   always_comb begin
      two_s = $signed({2'b00, a_s_ff, 1'b0});
      t5    = $signed({3'b000, a_s_ff}) + $signed({2'b00, a_u_ff, 1'b0})
              - $signed({2'b00, a_v_ff, 1'b0});
      t6    = $signed({3'b000, a_s_ff}) + $signed({3'b000, a_u_ff})
              - $signed({3'b000, a_v_ff});
      t7    = $signed({3'b000, a_da_ff}) + $signed({3'b000, a_db_ff});

      b_ctl_in.valid      = a_valid_ff;
      b_ctl_in.magnitude  = (a_mode_ff == cpl_pkg::MODE_MAGNITUDE);
      b_ctl_in.full_scale = a_s_ff;
      case (a_mode_ff)
         cpl_pkg::MODE_MAGNITUDE:    b_ctl_in.alt_result = '0;
         cpl_pkg::MODE_AVERAGE:
            b_ctl_in.alt_result = half_even({1'b0, a_u_ff} + {1'b0, a_v_ff});
         cpl_pkg::MODE_DIFFERENCE:
            b_ctl_in.alt_result = (a_u_ff > a_v_ff) ? a_u_ff - a_v_ff : a_v_ff - a_u_ff;
         cpl_pkg::MODE_MAX:
            b_ctl_in.alt_result = (a_u_ff > a_v_ff) ? a_u_ff : a_v_ff;
         cpl_pkg::MODE_MIN:
            b_ctl_in.alt_result = (a_u_ff < a_v_ff) ? a_u_ff : a_v_ff;
         cpl_pkg::MODE_EXTRACTCLIP:  b_ctl_in.alt_result = half_even(clip_dbl(t5, two_s));
         cpl_pkg::MODE_EXTRACTSCALE: b_ctl_in.alt_result = half_even(clip_dbl(t6, two_s));
         cpl_pkg::MODE_SUMCLIP:      b_ctl_in.alt_result = half_even(clip_dbl(t7, two_s));
         default:                    b_ctl_in.alt_result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         b_ctl_ff <= b_ctl_in;
      end
      if (adv) begin
         b_sqa_ff <= (2*W)'(a_da_ff) * (2*W)'(a_da_ff);
         b_sqb_ff <= (2*W)'(a_db_ff) * (2*W)'(a_db_ff);
      end
   end

   // (2U-S)^2 + (2V-S)^2 is always even
   assign c_q_in = (2*W)'(({1'b0, b_sqa_ff} + {1'b0, b_sqb_ff}) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         c_ctl_ff <= b_ctl_ff;
      end
      if (adv) begin
         c_q_ff <= c_q_in;
      end
   end

   assign ctl_out = c_ctl_ff;
   assign q_out   = c_q_ff;

endmodule

// File: rtl/cpl_sqrt_step.sv
`timescale 1ns / 1ps
// One registered step of the digit-by-digit square root.
module cpl_sqrt_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [cpl_pkg::SQ_W-1:0]      step_bit,
   input  cpl_pkg::pipe_ctl_type         ctl_in,
   input  logic [cpl_pkg::SQ_W-1:0]      rem_in,
   input  logic [cpl_pkg::SQ_W-1:0]      root_in,
   output cpl_pkg::pipe_ctl_type         ctl_out,
   output logic [cpl_pkg::SQ_W-1:0]      rem_out,
   output logic [cpl_pkg::SQ_W-1:0]      root_out
);

   localparam int N = cpl_pkg::SQ_W;

   cpl_pkg::pipe_ctl_type  ctl_ff;
   logic [N-1:0]           rem_ff, root_ff, rem_nxt, root_nxt;
   logic [N:0]             trial;

   always_comb begin
      trial = {1'b0, root_in} + {1'b0, step_bit};
      if ({1'b0, rem_in} >= trial) begin
         rem_nxt  = rem_in - trial[N-1:0];
         root_nxt = (root_in >> 1) + step_bit;
      end else begin
         rem_nxt  = rem_in;
         root_nxt = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
      if (adv) begin
         rem_ff  <= rem_nxt;
         root_ff <= root_nxt;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

// File: rtl/cpl_back.sv
`timescale 1ns / 1ps
// Rounds the root to nearest, picks the mode result, holds the output register.
module cpl_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  cpl_pkg::pipe_ctl_type             ctl_in,
   input  logic [cpl_pkg::SQ_W-1:0]          rem_in,
   input  logic [cpl_pkg::SAMPLE_W-1:0]      root_in,
   cpl_rsp_if.source                         rsp_if
);

   localparam int W = cpl_pkg::SAMPLE_W;

   logic            valid_ff;
   logic [W-1:0]    luma_ff, luma_in;
   logic [W:0]      rounded;

   always_comb begin
      // remainder above the root means the value sits past the midpoint
      rounded = {1'b0, root_in} + (W+1)'(rem_in > cpl_pkg::SQ_W'(root_in));
      if (!ctl_in.magnitude)                       luma_in = ctl_in.alt_result;
      else if (rounded > {1'b0, ctl_in.full_scale}) luma_in = ctl_in.full_scale;
      else                                         luma_in = rounded[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_in.valid;
      end
      if (adv) begin
         luma_ff <= luma_in;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.luma_value = luma_ff;

endmodule

// File: rtl/chroma_pair_to_luma_visualizer.sv
`timescale 1ns / 1ps
// channel   dir   handshake            payload
// req_if    in    valid / ready        u_sample[15:0], v_sample[15:0]
// rsp_if    out   valid / ready        luma_value[15:0]
// csr       in    csr_we (no ready)    csr_index[0], csr_wdata[4:0]
//
// One transaction per clock unless the pipe is held; three front stages,
// sixteen square-root stages (one result bit each), one output register.
// Reset is synchronous: it empties the pipe and sets mode 0, depth 8.
// The whole pipe advances together; it holds only while the output register
// is full and rsp_if.ready is low, and req_if.ready is low in exactly that case.
`include "chroma_pair_to_luma_visualizer_macros.svh"
module chroma_pair_to_luma_visualizer (
   input  logic                          clock,
   input  logic                          reset,
   cpl_req_if.sink                       req_if,
   cpl_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [cpl_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int STEPS = cpl_pkg::SQRT_STEPS;
   localparam int N     = cpl_pkg::SQ_W;
   localparam int W     = cpl_pkg::SAMPLE_W;

   cpl_pkg::mode_type                 mode_ff, mode_in;
   logic [cpl_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic                              adv;
   logic                              root_top_zero;

   cpl_pkg::pipe_ctl_type             ctl_chain  [0:STEPS];
   logic [N-1:0]                      rem_chain  [0:STEPS];
   logic [N-1:0]                      root_chain [0:STEPS];

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      if (csr_we && csr_index == cpl_pkg::CSR_MODE) begin
         mode_in = cpl_pkg::mode_type'(csr_wdata[2:0]);
      end
      if (csr_we && csr_index == cpl_pkg::CSR_DEPTH) begin
         depth_in = csr_wdata[cpl_pkg::DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cpl_pkg::MODE_MAGNITUDE;
         depth_ff <= cpl_pkg::DEPTH_RESET;
      end else begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
      end
   end

   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;

   cpl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_if.valid),
      .u_sample (req_if.u_sample),
      .v_sample (req_if.v_sample),
      .mode     (mode_ff),
      .depth    (depth_ff),
      .ctl_out  (ctl_chain[0]),
      .q_out    (rem_chain[0])
   );

   assign root_chain[0] = '0;

   for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
      localparam logic [N-1:0] STEP_BIT = N'(1) << (N - 2 - 2 * i);
      cpl_sqrt_step u_step (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step_bit (STEP_BIT),
         .ctl_in   (ctl_chain[i]),
         .rem_in   (rem_chain[i]),
         .root_in  (root_chain[i]),
         .ctl_out  (ctl_chain[i+1]),
         .rem_out  (rem_chain[i+1]),
         .root_out (root_chain[i+1])
      );
   end

   cpl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl_chain[STEPS]),
      .rem_in  (rem_chain[STEPS]),
      .root_in (root_chain[STEPS][W-1:0]),
      .rsp_if  (rsp_if)
   );

   assign root_top_zero = (root_chain[STEPS][N-1:W] == '0);

   `CPL_ASSERT_IMP(a_ready_when_empty, reset, !rsp_if.valid, req_if.ready, "ready low while empty")
   `CPL_ASSERT_NXT(a_reset_empties, 1'b0, reset, !rsp_if.valid, "output valid right after reset")
   `CPL_ASSERT_NXT(a_stall_holds_pipe, reset, !adv, $stable(ctl_chain[STEPS]), "pipe not held")
   `CPL_ASSERT_IMP(a_root_fits, reset, ctl_chain[STEPS].valid, root_top_zero, "root too wide")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 25;
   localparam int LONG_HOLD = 80;

   class luma_scoreboard;
      cpl_pkg::mode_type             mode_reg;
      logic [cpl_pkg::CSR_W-1:0]     depth_reg;
      logic [cpl_pkg::SAMPLE_W-1:0]  expected_luma[$];
      int                            mismatch_count;

      function void set_register(logic index, logic [cpl_pkg::CSR_W-1:0] value);
         if (index == cpl_pkg::CSR_MODE) begin
            mode_reg = cpl_pkg::mode_type'(value[2:0]);
         end else begin
            depth_reg = value;
         end
      endfunction

      // full scale with depth clamped to 8..16
      function longint scale();
         int d;
         d = depth_reg;
         if (d < 8) d = 8;
         if (d > cpl_pkg::SAMPLE_W) d = cpl_pkg::SAMPLE_W;
         return (longint'(1) << d) - 1;
      endfunction

      // halve a doubled value, ties to even
      function longint halve_even(longint t);
         longint q;
         q = t >>> 1;
         if (t[0] && q[0]) q++;
         return q;
      endfunction

      function longint floor_root(longint n);
         longint res;
         longint trial;
         res = 0;
         for (int b = 20; b >= 0; b--) begin
            trial = res | (longint'(1) << b);
            if (trial * trial <= n) res = trial;
         end
         return res;
      endfunction

      function logic [cpl_pkg::SAMPLE_W-1:0] predict_luma(
            logic [cpl_pkg::SAMPLE_W-1:0] u_in,
            logic [cpl_pkg::SAMPLE_W-1:0] v_in);
         longint s, u, v, a, b, q, f, t, r;
         s = scale();
         u = longint'(u_in) & s;
         v = longint'(v_in) & s;
         case (mode_reg)
            cpl_pkg::MODE_MAGNITUDE: begin
               a = 2 * u - s;
               b = 2 * v - s;
               q = (a * a + b * b) >>> 1;
               f = floor_root(q);
               if (q - f * f > f) f++;
               r = f;
            end
            cpl_pkg::MODE_AVERAGE:    r = halve_even(u + v);
            cpl_pkg::MODE_DIFFERENCE: r = (u > v) ? u - v : v - u;
            cpl_pkg::MODE_MAX:        r = (u > v) ? u : v;
            cpl_pkg::MODE_MIN:        r = (u < v) ? u : v;
            cpl_pkg::MODE_EXTRACTCLIP, cpl_pkg::MODE_EXTRACTSCALE: begin
               t = (mode_reg == cpl_pkg::MODE_EXTRACTCLIP) ? s + 2 * u - 2 * v
                                                           : s + u - v;
               if (t < 0) t = 0;
               if (t > 2 * s) t = 2 * s;
               r = halve_even(t);
            end
            default: begin
               a = 2 * u - s;
               b = 2 * v - s;
               t = (a < 0 ? -a : a) + (b < 0 ? -b : b);
               if (t > 2 * s) t = 2 * s;
               r = halve_even(t);
            end
         endcase
         if (r > s) r = s;
         return r[cpl_pkg::SAMPLE_W-1:0];
      endfunction

      function void note_pair(logic [cpl_pkg::SAMPLE_W-1:0] u_in,
                              logic [cpl_pkg::SAMPLE_W-1:0] v_in);
         expected_luma.push_back(predict_luma(u_in, v_in));
      endfunction

      function void check_luma(logic [cpl_pkg::SAMPLE_W-1:0] actual);
         logic [cpl_pkg::SAMPLE_W-1:0] want;
         if (expected_luma.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected luma transaction, expected none, actual %0d",
                     $time, actual);
         end else begin
            want = expected_luma.pop_front();
            if (actual !== want) begin
               mismatch_count++;
               $display("%0t: luma_value mismatch, expected %0d, actual %0d",
                        $time, want, actual);
            end
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic                         csr_index;
   logic [cpl_pkg::CSR_W-1:0]    csr_wdata;

   cpl_req_if req_if ();
   cpl_rsp_if rsp_if ();

   chroma_pair_to_luma_visualizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   luma_scoreboard luma = new;

   bit  req_idle;
   bit  rsp_idle;
   int  hold_requested;
   int  hold_served;
   int  stall_left;
   int  cycle_count;
   int  depth_choices[16] = '{16, 8, 31, 0, 12, 17, 7, 16, 8, 16, 9, 15, 4, 16, 10, 24};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) luma.check_luma(rsp_if.luma_value);
   end

   // result side: random stall bursts, plus long holds on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (rsp_idle && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_pair(logic [cpl_pkg::SAMPLE_W-1:0] u_in,
                            logic [cpl_pkg::SAMPLE_W-1:0] v_in);
      if (req_idle && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.u_sample <= u_in;
      req_if.v_sample <= v_in;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      luma.note_pair(u_in, v_in);
      @(negedge clock);
   endtask

   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (luma.expected_luma.size() != 0) @(negedge clock);
   endtask

   // pipe is empty here; both registers are written back to back
   task automatic program_setting(cpl_pkg::mode_type sel, logic [cpl_pkg::CSR_W-1:0] depth);
      logic [cpl_pkg::CSR_W-1:0] mode_word;
      mode_word = {2'($urandom_range(0, 3)), sel};
      csr_we    <= 1'b1;
      csr_index <= cpl_pkg::CSR_MODE;
      csr_wdata <= mode_word;
      @(negedge clock);
      csr_index <= cpl_pkg::CSR_DEPTH;
      csr_wdata <= depth;
      @(negedge clock);
      csr_we <= 1'b0;
      luma.set_register(cpl_pkg::CSR_MODE, mode_word);
      luma.set_register(cpl_pkg::CSR_DEPTH, depth);
   endtask

   function automatic logic [cpl_pkg::SAMPLE_W-1:0] pick_sample();
      longint s;
      s = luma.scale();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return s[cpl_pkg::SAMPLE_W-1:0];
         2: return cpl_pkg::SAMPLE_W'(s >>> 1);
         3: return cpl_pkg::SAMPLE_W'((s >>> 1) + 1);
         4: return '1;
         5: return cpl_pkg::SAMPLE_W'($urandom_range(0, int'(s)));
         default: return cpl_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.u_sample = '0;
      req_if.v_sample = '0;
      rsp_if.ready    = 1'b0;
      csr_we          = 1'b0;
      csr_index       = cpl_pkg::CSR_MODE;
      csr_wdata       = '0;
      req_idle        = 1'b1;
      rsp_idle        = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners per mode at depth 8; upper sample bits must be dropped
      for (int m = 0; m < 8; m++) begin
         program_setting(cpl_pkg::mode_type'(m), cpl_pkg::CSR_W'(8));
         send_pair(16'h0000, 16'hFFFF);
         send_pair(16'hFFFF, 16'h0000);
         send_pair(16'h1280, 16'hA37F);
         finish_phase();
      end

      depth_choices[12] = $urandom_range(0, 31);
      for (int p = 0; p < 16; p++) begin
         program_setting(cpl_pkg::mode_type'(p % 8), cpl_pkg::CSR_W'(depth_choices[p]));
         // sender offers every cycle during a long hold so the pipe fills
         req_idle = (p < 13) && (p != 2) && (p != 9);
         rsp_idle = (p < 13);
         if (p == 2 || p == 9) hold_requested++;
         repeat (36) send_pair(pick_sample(), pick_sample());
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (luma.mismatch_count == 0 && luma.expected_luma.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
